FILE: rtl/lrdi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrdi_pkg
// Shared types and constants of the remap depth interpolator.
// ----------------------------------------------------------------------------
package lrdi_pkg;

	// Fixed field widths of the item and result ports
	localparam int SAMPLE_PORT_W   = 16;
	localparam int WEIGHT_W        = 17;
	localparam int PIXEL_W         = 16;
	localparam int RATIO_W         = 16;
	localparam int RATIO_FRAC_BITS = 16;
	localparam int MODE_W          = 2;
	localparam int STATUS_W        = 2;

	// Register reset values and APB data width
	localparam logic [RATIO_W-1:0] SKIP_RATIO_RESET = 16'd3076;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Interpolation modes; the unused code behaves as depth mode
	typedef enum logic [MODE_W-1:0] {
		MODE_NEAREST  = 2'd0,
		MODE_BILINEAR = 2'd1,
		MODE_DEPTH    = 2'd2
	} lrdi_mode_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_WRITTEN = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_ZERO    = 2'd2,
		STATUS_DISCONT = 2'd3
	} lrdi_status_t;

	// Work class decided by the front end
	typedef enum logic [2:0] {
		KIND_INVALID = 3'd0,
		KIND_NEAREST = 3'd1,
		KIND_ZERO    = 3'd2,
		KIND_BLEND   = 3'd3,
		KIND_DEPTH   = 3'd4
	} lrdi_kind_t;

endpackage : lrdi_pkg
`default_nettype wire

FILE: rtl/lrdi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrdi_queue
// Small show-ahead queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module lrdi_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rdata    = mem_q[rptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill level exceeds depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue fill level did not rise on write");
`endif

endmodule : lrdi_queue
`default_nettype wire

FILE: rtl/lrdi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrdi_front
// Accepts items, classifies them and finds neighbour min and max; hands
// the classified work to the back end through a short queue.
// ----------------------------------------------------------------------------
module lrdi_front import lrdi_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [MODE_W-1:0]            mode,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         entry_valid,
	input  wire logic [3:0][WEIGHT_W-1:0]     weights,
	input  wire logic [3:0][SAMPLE_PORT_W-1:0] samples,
	input  wire logic                         head_pop,
	output logic                              head_valid,
	output lrdi_kind_t                        head_kind,
	output logic [3:0][SAMPLE_BITS-1:0]       head_smp,
	output logic [3:0][WEIGHT_W-1:0]          head_wgt,
	output logic [SAMPLE_BITS-1:0]            head_hi,
	output logic [SAMPLE_BITS-1:0]            head_lo
);

	localparam int QDEPTH  = 2;
	localparam int ENTRY_W = 3 + 4 * SAMPLE_BITS + 4 * WEIGHT_W + 2 * SAMPLE_BITS;

	logic                          v_s1;
	logic                          ev_s1;
	logic [MODE_W-1:0]             mode_s1;
	logic [3:0][WEIGHT_W-1:0]      wgt_s1;
	logic [3:0][SAMPLE_BITS-1:0]   smp_s1;
	logic                          ready_s1;
	logic                          q_full;
	logic                          q_wr;
	lrdi_kind_t                    kind;
	logic                          any_zero;
	logic [SAMPLE_BITS-1:0]        hi_a;
	logic [SAMPLE_BITS-1:0]        hi_b;
	logic [SAMPLE_BITS-1:0]        lo_a;
	logic [SAMPLE_BITS-1:0]        lo_b;
	logic [SAMPLE_BITS-1:0]        hi;
	logic [SAMPLE_BITS-1:0]        lo;
	logic [ENTRY_W-1:0]            wdata;
	logic [ENTRY_W-1:0]            rdata;

	assign ready_s1 = !v_s1 || !q_full;
	assign full     = !ready_s1;
	assign q_wr     = v_s1;

	// Capture the item, keeping only the live sample bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && push) begin
			ev_s1   <= entry_valid;
			mode_s1 <= mode;
			wgt_s1  <= weights;
			for (int i = 0; i < 4; i++) begin
				smp_s1[i] <= samples[i][SAMPLE_BITS-1:0];
			end
		end
	end

	// Find neighbour range and zero neighbours
	always_comb begin
		any_zero = (smp_s1[0] == '0) || (smp_s1[1] == '0) ||
			(smp_s1[2] == '0) || (smp_s1[3] == '0);
		hi_a = (smp_s1[0] > smp_s1[1]) ? smp_s1[0] : smp_s1[1];
		hi_b = (smp_s1[2] > smp_s1[3]) ? smp_s1[2] : smp_s1[3];
		lo_a = (smp_s1[0] < smp_s1[1]) ? smp_s1[0] : smp_s1[1];
		lo_b = (smp_s1[2] < smp_s1[3]) ? smp_s1[2] : smp_s1[3];
		hi   = (hi_a > hi_b) ? hi_a : hi_b;
		lo   = (lo_a < lo_b) ? lo_a : lo_b;
	end

	// Classify the work
	always_comb begin
		if (!ev_s1) begin
			kind = KIND_INVALID;
		end else if (mode_s1 == MODE_NEAREST) begin
			kind = KIND_NEAREST;
		end else if (mode_s1 == MODE_BILINEAR) begin
			kind = KIND_BLEND;
		end else if (any_zero) begin
			kind = KIND_ZERO;
		end else begin
			kind = KIND_DEPTH;
		end
	end

	assign wdata = {kind, smp_s1, wgt_s1, hi, lo};

	lrdi_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (wdata),
		.rd       (head_pop),
		.rdata    (rdata),
		.full     (q_full),
		.nonempty (head_valid)
	);

	// Split the queue head back into fields
	assign head_kind = lrdi_kind_t'(rdata[ENTRY_W-1 -: 3]);
	assign {head_smp, head_wgt, head_hi, head_lo} = rdata[ENTRY_W-4:0];

endmodule : lrdi_front
`default_nettype wire

FILE: rtl/lrdi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrdi_back
// Weighted blend, rounding, saturation and discontinuity test in two
// stages; the second stage is the result register.
// ----------------------------------------------------------------------------
module lrdi_back import lrdi_pkg::*; #(
	parameter int SAMPLE_BITS      = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [RATIO_W-1:0]         ratio,
	input  wire logic                       head_valid,
	input  wire lrdi_kind_t                 head_kind,
	input  wire logic [3:0][SAMPLE_BITS-1:0] head_smp,
	input  wire logic [3:0][WEIGHT_W-1:0]   head_wgt,
	input  wire logic [SAMPLE_BITS-1:0]     head_hi,
	input  wire logic [SAMPLE_BITS-1:0]     head_lo,
	output logic                            head_pop,
	input  wire logic                       pop,
	output logic                            empty,
	output logic [PIXEL_W-1:0]              pixel_out,
	output lrdi_status_t                    status
);

	localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
	localparam int SUM_W  = SAMPLE_BITS + WEIGHT_W + 2;
	localparam int CMP_W  = SAMPLE_BITS + RATIO_FRAC_BITS;
	localparam int RES_W  = SUM_W - WEIGHT_FRAC_BITS;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (WEIGHT_FRAC_BITS - 1);
	localparam logic [RES_W-1:0] SMAX = RES_W'({SAMPLE_BITS{1'b1}});

	logic                        v_s2;
	lrdi_kind_t                  kind_s2;
	logic [SAMPLE_BITS-1:0]      near_s2;
	logic [3:0][PROD_W-1:0]      prod_s2;
	logic [CMP_W-1:0]            span_s2;
	logic [CMP_W-1:0]            thr_s2;
	logic                        v_s3;
	logic                        ready_s2;
	logic                        ready_s3;
	logic [SUM_W-1:0]            sum;
	logic [RES_W-1:0]            res;
	logic [SAMPLE_BITS-1:0]      blend;
	logic                        discont;
	logic [PIXEL_W-1:0]          pix_d;
	lrdi_status_t                stat_d;

	assign ready_s3 = !v_s3 || pop;
	assign ready_s2 = !v_s2 || ready_s3;
	assign head_pop = head_valid && ready_s2;
	assign empty    = !v_s3;

	// Stage 2: products and discontinuity operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			kind_s2 <= head_kind;
			near_s2 <= head_smp[0];
			for (int i = 0; i < 4; i++) begin
				prod_s2[i] <= PROD_W'(head_smp[i]) * PROD_W'(head_wgt[i]);
			end
			span_s2 <= {head_hi - head_lo, {RATIO_FRAC_BITS{1'b0}}};
			thr_s2  <= CMP_W'(ratio) * CMP_W'(head_lo);
		end
	end

	// Sum, round half up and saturate
	always_comb begin
		sum = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) +
			SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]) + HALF;
		res = sum[SUM_W-1:WEIGHT_FRAC_BITS];
		blend = (res > SMAX) ? SAMPLE_BITS'(SMAX) : res[SAMPLE_BITS-1:0];
		discont = (span_s2 > thr_s2);
	end

	// Pick the result for the work class
	always_comb begin
		case (kind_s2)
			KIND_NEAREST: begin
				pix_d  = PIXEL_W'(near_s2);
				stat_d = STATUS_WRITTEN;
			end
			KIND_ZERO: begin
				pix_d  = '0;
				stat_d = STATUS_ZERO;
			end
			KIND_BLEND: begin
				pix_d  = PIXEL_W'(blend);
				stat_d = STATUS_WRITTEN;
			end
			KIND_DEPTH: begin
				pix_d  = discont ? '0 : PIXEL_W'(blend);
				stat_d = discont ? STATUS_DISCONT : STATUS_WRITTEN;
			end
			default: begin
				pix_d  = '0;
				stat_d = STATUS_INVALID;
			end
		endcase
	end

	// Stage 3: result register, held until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			pixel_out <= pix_d;
			status    <= stat_d;
		end
	end

`ifndef SYNTHESIS
	a_zero_when_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && status != STATUS_WRITTEN) |-> (pixel_out == '0))
		else $error("pixel not zero on unwritten status");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !pop) |=> (v_s3 && $stable(pixel_out) && $stable(status)))
		else $error("result changed while stalled");
`endif

endmodule : lrdi_back
`default_nettype wire

FILE: rtl/lut_remap_depth_interpolator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lut_remap_depth_interpolator_core
// Remap interpolator: nearest, bilinear or depth-checked bilinear output
// for one destination pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the lookup entry (valid mark, four Q1.16 weights,
//   four fetched neighbours) and raise push; the item is taken on a clock
//   edge with push high and full low.
//   Result channel: while empty is low, pixel_out and status show the oldest
//   result; raise pop to take it.
//   Configuration: APB writes to interp_mode (address 0) and skip_ratio
//   (any other address); pready is tied high. Write only while idle.
//   Throughput: one item per cycle while pop keeps up and full stays low,
//   set by the front stage and the two-stage multiply/sum back end.
//   A two-entry queue between front and back end absorbs short stalls; when
//   pop is held low the back end fills, then the queue, then full rises.
//   Reset: all queues empty, interp_mode = nearest, skip_ratio = 3076.
// ----------------------------------------------------------------------------
module lut_remap_depth_interpolator_core import lrdi_pkg::*; #(
	parameter int SAMPLE_BITS      = 16,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_W-1:0]    paddr,
	input  wire logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]         prdata,
	output logic                          pready,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic                     entry_valid,
	input  wire logic [WEIGHT_W-1:0]      weight_ul,
	input  wire logic [WEIGHT_W-1:0]      weight_ur,
	input  wire logic [WEIGHT_W-1:0]      weight_ll,
	input  wire logic [WEIGHT_W-1:0]      weight_lr,
	input  wire logic [SAMPLE_PORT_W-1:0] sample_ul,
	input  wire logic [SAMPLE_PORT_W-1:0] sample_ur,
	input  wire logic [SAMPLE_PORT_W-1:0] sample_ll,
	input  wire logic [SAMPLE_PORT_W-1:0] sample_lr,
	input  wire logic                     pop,
	output logic                          empty,
	output logic [PIXEL_W-1:0]            pixel_out,
	output logic [STATUS_W-1:0]           status
);

	logic [MODE_W-1:0]            mode_q;
	logic [RATIO_W-1:0]           ratio_q;
	logic                         cfg_wr;
	logic                         sel_ratio;
	logic                         head_valid;
	logic                         head_pop;
	lrdi_kind_t                   head_kind;
	logic [3:0][SAMPLE_BITS-1:0]  head_smp;
	logic [3:0][WEIGHT_W-1:0]     head_wgt;
	logic [SAMPLE_BITS-1:0]       head_hi;
	logic [SAMPLE_BITS-1:0]       head_lo;
	lrdi_status_t                 status_e;

	// Configuration registers
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign sel_ratio = |paddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NEAREST;
			ratio_q <= SKIP_RATIO_RESET;
		end else if (cfg_wr) begin
			if (sel_ratio) begin
				ratio_q <= pwdata[RATIO_W-1:0];
			end else begin
				mode_q <= pwdata[MODE_W-1:0];
			end
		end
	end

	assign prdata = sel_ratio ? APB_DATA_W'(ratio_q) : APB_DATA_W'(mode_q);

	lrdi_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.push        (push),
		.full        (full),
		.entry_valid (entry_valid),
		.weights     ({weight_lr, weight_ll, weight_ur, weight_ul}),
		.samples     ({sample_lr, sample_ll, sample_ur, sample_ul}),
		.head_pop    (head_pop),
		.head_valid  (head_valid),
		.head_kind   (head_kind),
		.head_smp    (head_smp),
		.head_wgt    (head_wgt),
		.head_hi     (head_hi),
		.head_lo     (head_lo)
	);

	lrdi_back #(
		.SAMPLE_BITS      (SAMPLE_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.ratio      (ratio_q),
		.head_valid (head_valid),
		.head_kind  (head_kind),
		.head_smp   (head_smp),
		.head_wgt   (head_wgt),
		.head_hi    (head_hi),
		.head_lo    (head_lo),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.pixel_out  (pixel_out),
		.status     (status_e)
	);

	assign status = status_e;

endmodule : lut_remap_depth_interpolator_core
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the remap depth interpolator core. An initial
// block programs the mode and ratio registers over APB between phases and
// fills a queue of destination pixels: first a directed set of corner
// cases, then random lookup entries. A clocked driver offers them with
// random gaps, a clocked monitor pops results with random stalls and one
// long hold-off, and every result is compared with a local prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import lrdi_pkg::*;

	localparam int                    WEIGHT_FRAC    = 16;
	localparam int                    DRAIN_CYCLES   = 8;
	localparam int                    LONG_HOLD      = 400;
	localparam int                    WATCHDOG_LIMIT = 2000;
	localparam int                    RANDOM_PHASES  = 8;
	localparam int                    PHASE_ITEMS    = 125;
	localparam logic [APB_ADDR_W-1:0] ADDR_INTERP_MODE = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_SKIP_RATIO  = 3'd4;
	localparam logic [MODE_W-1:0]     MODE_UNUSED      = 2'd3;
	localparam logic [WEIGHT_W-1:0]   W_ONE            = 17'd65536;
	localparam logic [WEIGHT_W-1:0]   W_ALL            = 17'h1FFFF;

	// One lookup entry; index 0..3 is ul, ur, ll, lr
	typedef struct packed {
		logic                                valid;
		logic [3:0][WEIGHT_W-1:0]            weight;
		logic [3:0][SAMPLE_PORT_W-1:0]       sample;
	} pixel_item_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		lrdi_status_t       status;
	} pixel_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0]    pwdata = '0;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;
	logic                     push = 1'b0;
	logic                     full;
	logic                     entry_valid = 1'b0;
	logic [WEIGHT_W-1:0]      weight_ul = '0;
	logic [WEIGHT_W-1:0]      weight_ur = '0;
	logic [WEIGHT_W-1:0]      weight_ll = '0;
	logic [WEIGHT_W-1:0]      weight_lr = '0;
	logic [SAMPLE_PORT_W-1:0] sample_ul = '0;
	logic [SAMPLE_PORT_W-1:0] sample_ur = '0;
	logic [SAMPLE_PORT_W-1:0] sample_ll = '0;
	logic [SAMPLE_PORT_W-1:0] sample_lr = '0;
	logic                     pop = 1'b0;
	logic                     empty;
	logic [PIXEL_W-1:0]       pixel_out;
	logic [STATUS_W-1:0]      status;

	// Register copies used by the prediction
	logic [MODE_W-1:0]  cfg_mode = MODE_NEAREST;
	logic [RATIO_W-1:0] cfg_ratio = SKIP_RATIO_RESET;

	pixel_item_t   pending_pixels[$];
	pixel_result_t expected_pixels[$];
	pixel_item_t   offered_item;
	logic          offering;
	int            send_gap, send_run, pop_gap, recv_run, hold_left;
	bit            long_hold_req = 1'b0;
	int            pixels_sent = 0;
	int            pixels_checked = 0;
	int            error_count = 0;
	int            settings_count = 0;
	int            full_cycles = 0;
	int            stall_cycles = 0;
	int            status_seen[4] = '{0, 0, 0, 0};

	lut_remap_depth_interpolator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.push        (push),
		.full        (full),
		.entry_valid (entry_valid),
		.weight_ul   (weight_ul),
		.weight_ur   (weight_ur),
		.weight_ll   (weight_ll),
		.weight_lr   (weight_lr),
		.sample_ul   (sample_ul),
		.sample_ur   (sample_ur),
		.sample_ll   (sample_ll),
		.sample_lr   (sample_lr),
		.pop         (pop),
		.empty       (empty),
		.pixel_out   (pixel_out),
		.status      (status)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Expected destination pixel for one lookup entry under the current registers
	function automatic pixel_result_t remap_pixel(input pixel_item_t it);
		pixel_result_t r;
		logic [63:0]   lo, hi, acc;
		int            k;
		r.pixel = '0;
		r.status = STATUS_WRITTEN;
		if (!it.valid) begin
			r.status = STATUS_INVALID;
			return r;
		end
		if (cfg_mode == MODE_NEAREST) begin
			r.pixel = it.sample[0];
			return r;
		end
		// depth check: the unused mode code behaves as depth mode
		if (cfg_mode != MODE_BILINEAR) begin
			lo = it.sample[0];
			hi = it.sample[0];
			for (k = 0; k < 4; k++) begin
				if (it.sample[k] == 0) begin
					r.status = STATUS_ZERO;
					return r;
				end
				if (it.sample[k] < lo) lo = it.sample[k];
				if (it.sample[k] > hi) hi = it.sample[k];
			end
			if (((hi - lo) << RATIO_FRAC_BITS) > 64'(cfg_ratio) * lo) begin
				r.status = STATUS_DISCONT;
				return r;
			end
		end
		// exact weighted sum, round half up, saturate
		acc = 0;
		for (k = 0; k < 4; k++)
			acc += 64'(it.sample[k]) * 64'(it.weight[k]);
		acc = (acc + (64'd1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
		r.pixel = (acc > 64'hFFFF) ? 16'hFFFF : acc[PIXEL_W-1:0];
		return r;
	endfunction

	// Mostly short gaps, a few long ones, and occasional runs with none
	function automatic int next_gap(inout int run_left);
		int r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) run_left = $urandom_range(16, 64);
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic pixel_item_t make_item(input logic v,
			input logic [WEIGHT_W-1:0] wul, input logic [WEIGHT_W-1:0] wur,
			input logic [WEIGHT_W-1:0] wll, input logic [WEIGHT_W-1:0] wlr,
			input logic [SAMPLE_PORT_W-1:0] sul, input logic [SAMPLE_PORT_W-1:0] sur,
			input logic [SAMPLE_PORT_W-1:0] sll, input logic [SAMPLE_PORT_W-1:0] slr);
		pixel_item_t it;
		it.valid = v;
		it.weight = {wlr, wll, wur, wul};
		it.sample = {slr, sll, sur, sul};
		return it;
	endfunction

	function automatic pixel_item_t random_item();
		pixel_item_t it;
		logic [63:0] fx, fy, base, spread, s, w;
		int          k, wkind, skind, zero_at;
		it.valid = ($urandom_range(0, 9) != 0);
		wkind = $urandom_range(0, 9);
		skind = $urandom_range(0, 9);
		// weights: proper bilinear split, extremes, or anything the port takes
		fx = $urandom_range(0, 65536);
		fy = $urandom_range(0, 65536);
		for (k = 0; k < 4; k++) begin
			if (wkind < 6)
				w = (((k & 1) ? fx : 65536 - fx) * ((k & 2) ? fy : 65536 - fy)) >> 16;
			else if (wkind < 8)
				w = $urandom_range(0, 1) ? 64'(W_ONE) : 64'd0;
			else
				w = $urandom_range(0, 131071);
			it.weight[k] = w[WEIGHT_W-1:0];
		end
		// samples: clustered around a base so depth checks pass near the threshold
		base = $urandom_range(1, 65535);
		spread = base >> $urandom_range(3, 12);
		zero_at = $urandom_range(0, 3);
		for (k = 0; k < 4; k++) begin
			s = base + $urandom_range(0, spread);
			if (s > 65535) s = 65535;
			if (skind == 5 || skind == 6) s = $urandom_range(0, 65535);
			if (skind == 7 && k == zero_at) s = 0;
			if (skind == 8) s = ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 1 : 65535);
			if (skind == 9) s = base;
			it.sample[k] = s[SAMPLE_PORT_W-1:0];
		end
		return it;
	endfunction

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_INTERP_MODE) cfg_mode = data[MODE_W-1:0];
		else cfg_ratio = data[RATIO_W-1:0];
		settings_count++;
	endtask

	// Hold until every pixel is sent and checked, then let the pipe drain
	task automatic wait_idle();
		do @(negedge clk); while (pending_pixels.size() != 0 || push || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Stimulus and phase sequencing
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// nearest neighbour
		write_reg(ADDR_INTERP_MODE, MODE_NEAREST);
		@(negedge clk);
		pending_pixels.push_back(make_item(0, W_ONE, W_ONE, W_ONE, W_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0));
		pending_pixels.push_back(make_item(1, W_ALL, W_ALL, W_ALL, W_ALL, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, W_ALL, 0, W_ONE, 1, 16'd12345, 1, 2, 3));
		wait_idle();

		// bilinear: saturation, zero weights, rounding at exactly one half
		write_reg(ADDR_INTERP_MODE, MODE_BILINEAR);
		@(negedge clk);
		pending_pixels.push_back(make_item(1, W_ONE, W_ONE, W_ONE, W_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, W_ALL, W_ALL, W_ALL, W_ALL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, 17'd32768, 0, 0, 0, 1, 0, 0, 0));
		pending_pixels.push_back(make_item(1, 17'd32767, 0, 0, 0, 1, 0, 0, 0));
		pending_pixels.push_back(make_item(1, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 1, 2, 3, 4));
		pending_pixels.push_back(make_item(0, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 1, 2, 3, 4));
		wait_idle();

		// depth: threshold met exactly, just over, zero in each position
		write_reg(ADDR_INTERP_MODE, MODE_DEPTH);
		write_reg(ADDR_SKIP_RATIO, 32'd32768);
		@(negedge clk);
		pending_pixels.push_back(make_item(1, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 2, 3, 3, 2));
		pending_pixels.push_back(make_item(1, 17'd16384, 17'd16384, 17'd16384, 17'd16384, 2, 4, 2, 2));
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 0, 100, 100, 100));
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 100, 0, 100, 100));
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 100, 100, 0, 100));
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 100, 100, 100, 0));
		pending_pixels.push_back(make_item(0, W_ONE, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// unused mode code with a zero ratio: any spread is a discontinuity
		write_reg(ADDR_INTERP_MODE, MODE_UNUSED);
		write_reg(ADDR_SKIP_RATIO, 32'd0);
		@(negedge clk);
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 1000, 1001, 1000, 1000));
		pending_pixels.push_back(make_item(1, W_ONE, W_ONE, W_ONE, W_ONE, 0, 0, 0, 0));
		wait_idle();

		// depth with the largest ratio
		write_reg(ADDR_INTERP_MODE, MODE_DEPTH);
		write_reg(ADDR_SKIP_RATIO, 32'd65535);
		@(negedge clk);
		pending_pixels.push_back(make_item(1, W_ONE, 0, 0, 0, 1, 2, 1, 1));
		pending_pixels.push_back(make_item(1, 17'd40000, 17'd25536, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF));
		pending_pixels.push_back(make_item(1, W_ONE, W_ONE, W_ONE, W_ONE, 1, 1, 1, 1));
		wait_idle();

		// random phases, each mode twice, various ratios
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: write_reg(ADDR_INTERP_MODE, MODE_DEPTH);
				1: write_reg(ADDR_INTERP_MODE, MODE_BILINEAR);
				2: write_reg(ADDR_INTERP_MODE, MODE_UNUSED);
				default: write_reg(ADDR_INTERP_MODE, MODE_NEAREST);
			endcase
			if (p == 3) write_reg(ADDR_SKIP_RATIO, 32'd0);
			else if (p == 6) write_reg(ADDR_SKIP_RATIO, 32'd65535);
			else if (p == 4) write_reg(ADDR_SKIP_RATIO, SKIP_RATIO_RESET);
			else if ($urandom_range(0, 1)) write_reg(ADDR_SKIP_RATIO, $urandom_range(0, 65535));
			else write_reg(ADDR_SKIP_RATIO, $urandom_range(1000, 6000));
			@(negedge clk);
			// let the result side back up until the input stalls
			if (p == 2) long_hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_pixels.push_back(random_item());
			wait_idle();
		end

		$display("summary: %0d pixels sent, %0d checked, %0d register writes, %0d full cycles",
			pixels_sent, pixels_checked, settings_count, full_cycles);
		$display("summary: status written %0d, invalid %0d, zero %0d, discontinuity %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// Driver: offer pending pixels, record the prediction on each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
			send_run = 0;
		end else begin
			offering = push;
			if (push && !full) begin
				expected_pixels.push_back(remap_pixel(offered_item));
				pixels_sent++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					offered_item = pending_pixels.pop_front();
					entry_valid <= offered_item.valid;
					weight_ul <= offered_item.weight[0];
					weight_ur <= offered_item.weight[1];
					weight_ll <= offered_item.weight[2];
					weight_lr <= offered_item.weight[3];
					sample_ul <= offered_item.sample[0];
					sample_ur <= offered_item.sample[1];
					sample_ll <= offered_item.sample[2];
					sample_lr <= offered_item.sample[3];
					push <= 1'b1;
					send_gap = next_gap(send_run);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: pop results with random stalls and compare with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
			recv_run = 0;
			hold_left = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result, pixel_out %0d status %0d", $time, pixel_out, status);
					error_count++;
				end else begin
					pixel_result_t want;
					want = expected_pixels.pop_front();
					status_seen[want.status]++;
					if (pixel_out !== want.pixel) begin
						$display("%0t: pixel_out mismatch, expected %0d, got %0d", $time, want.pixel, pixel_out);
						error_count++;
					end
					if (status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
						error_count++;
					end
				end
				pixels_checked++;
				pop_gap = next_gap(recv_run);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				pop <= 1'b0;
			end else if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n && full) full_cycles++;
		if ((push && !full) || (pop && !empty)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, stall_cycles);
			$display("tb_top: errors");
			$finish;
		end
	end

endmodule
